/* rtl/core/ffsa_pkg.sv */
// Shared types, sizes and codes of the first-fit segment allocator.
package ffsa_pkg;

  localparam int USED_SLOTS = 16;
  localparam int HOLE_SLOTS = USED_SLOTS + 1;
  localparam int ADDR_BITS  = 16;
  localparam int OWNER_BITS = 8;

  localparam int HIDX_W = $clog2(HOLE_SLOTS);
  localparam int HCNT_W = $clog2(HOLE_SLOTS + 1);
  localparam int UIDX_W = $clog2(USED_SLOTS);
  localparam int UCNT_W = $clog2(USED_SLOTS + 1);

  // Command codes.
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_NO_OWNER = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] len;
  } hole_t;

  typedef struct packed {
    logic [OWNER_BITS-1:0] owner;
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  len;
  } used_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] free_total;
    logic [ADDR_BITS-1:0] region_size;
    logic [ADDR_BITS-1:0] region_base;
    logic [2:0]           status;
  } result_t;

endpackage

/* rtl/core/ffsa_ram.sv */
// Generic single-write, single-read memory with registered read data.
module ffsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/core/ffsa_ctrl.sv */
// Sequencer that scans, shifts and rewrites the hole and used tables.
module ffsa_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [1:0]                       cmd_i,
  input  logic [ffsa_pkg::ADDR_BITS-1:0]   req_size_i,
  input  logic [ffsa_pkg::OWNER_BITS-1:0]  owner_id_i,
  input  logic [ffsa_pkg::ADDR_BITS-1:0]   cfg_size_i,
  input  logic [ffsa_pkg::ADDR_BITS-1:0]   cfg_base_i,
  output logic                             idle_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output ffsa_pkg::result_t                res_o
);
  import ffsa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_AS_RD, S_AS_CHK, S_UI_RD, S_UI_CHK, S_UI_PUT,
    S_FS_RD, S_FS_CHK, S_UR_RD, S_UR_WR, S_CO_RD, S_CO_CHK,
    S_HI_RD, S_HI_CHK, S_HI_PUT, S_HR_RD, S_HR_WR, S_DONE
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d, i_q, i_d, k_q, k_d;
  logic [UCNT_W-1:0] ucnt_q, ucnt_d, uk_q, uk_d;
  logic [ADDR_BITS-1:0] fsum_q, fsum_d, rb_q, rb_d, rs_q, rs_d, nb_q, nb_d, nl_q, nl_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic [2:0] st_q, st_d;
  logic below_q, below_d, above_q, above_d;
  logic h0rst_q, h0rst_d, hrd0_q;

  // Memory ports.
  logic              h_we;
  logic [HIDX_W-1:0] h_waddr, h_raddr;
  hole_t             h_wdata, h_rdata, hd;
  logic              u_we;
  logic [UIDX_W-1:0] u_waddr, u_raddr;
  used_t             u_wdata, ud;

  // Init and coalescing arithmetic.
  logic [ADDR_BITS:0]   span;
  logic [ADDR_BITS-1:0] init_len;
  logic [ADDR_BITS:0]   rel_end, hole_end;

  ffsa_ram #(.WIDTH($bits(hole_t)), .DEPTH(HOLE_SLOTS)) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  ffsa_ram #(.WIDTH($bits(used_t)), .DEPTH(USED_SLOTS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (ud)
  );

  // Hole entry 0 reads as its reset value until it is first written.
  always_comb begin
    hd = h_rdata;
    if (hrd0_q && h0rst_q) begin
      hd.base = '0;
      hd.len  = {ADDR_BITS{1'b1}};
    end
  end

  assign span     = (ADDR_BITS+1)'(1) << ADDR_BITS;
  assign init_len = ({1'b0, cfg_size_i} < (span - {1'b0, cfg_base_i})) ? cfg_size_i
                    : ADDR_BITS'(span - {1'b0, cfg_base_i});
  assign rel_end  = {1'b0, rb_q} + {1'b0, rs_q};
  assign hole_end = {1'b0, hd.base} + {1'b0, hd.len};

  // Next-state and memory control.
  always_comb begin
    state_d = state_q; ret_d = ret_q;
    hcnt_d = hcnt_q; ucnt_d = ucnt_q; i_d = i_q; k_d = k_q; uk_d = uk_q;
    fsum_d = fsum_q; rb_d = rb_q; rs_d = rs_q; nb_d = nb_q; nl_d = nl_q;
    owner_d = owner_q; st_d = st_q; below_d = below_q; above_d = above_q;
    h0rst_d = h0rst_q;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
    u_we = 1'b0; u_waddr = '0; u_wdata = '0; u_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          owner_d = owner_id_i;
          rs_d    = '0;
          rb_d    = '0;
          st_d    = ST_OK;
          i_d     = '0;
          state_d = S_DONE;
          case (cmd_i)
            CMD_INIT: begin
              h_we    = 1'b1;
              h_waddr = '0;
              h_wdata = '{base: cfg_base_i, len: init_len};
              hcnt_d  = (init_len != '0) ? HCNT_W'(1) : '0;
              ucnt_d  = '0;
              fsum_d  = init_len;
              rb_d    = cfg_base_i;
              rs_d    = init_len;
            end
            CMD_ALLOC: begin
              rs_d = req_size_i;
              if (req_size_i == '0) begin
                st_d = ST_ZERO;
                rs_d = '0;
              end else if (ucnt_q >= UCNT_W'(USED_SLOTS)) begin
                st_d = ST_FULL;
                rs_d = '0;
              end else begin
                state_d = S_AS_RD;
              end
            end
            CMD_FREE: state_d = S_FS_RD;
            default:  state_d = S_DONE;
          endcase
        end
      end

      // First-fit search over the holes; rs_q holds the request.
      S_AS_RD: begin
        if (i_q < hcnt_q) begin
          h_raddr = i_q[HIDX_W-1:0];
          state_d = S_AS_CHK;
        end else begin
          st_d    = ST_NO_FIT;
          rs_d    = '0;
          state_d = S_DONE;
        end
      end
      S_AS_CHK: begin
        if (hd.len >= rs_q) begin
          rb_d = hd.base;
          uk_d = ucnt_q;
          if (hd.len == rs_q) begin
            k_d     = i_q;
            ret_d   = S_UI_RD;
            state_d = S_HR_RD;
          end else begin
            h_we    = 1'b1;
            h_waddr = i_q[HIDX_W-1:0];
            h_wdata = '{base: hd.base + rs_q, len: hd.len - rs_q};
            state_d = S_UI_RD;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_AS_RD;
        end
      end

      // Sorted insert into the used table.
      S_UI_RD: begin
        if (uk_q != '0) begin
          u_raddr = UIDX_W'(uk_q - 1'b1);
          state_d = S_UI_CHK;
        end else begin
          state_d = S_UI_PUT;
        end
      end
      S_UI_CHK: begin
        if (ud.base >= rb_q) begin
          u_we    = 1'b1;
          u_waddr = uk_q[UIDX_W-1:0];
          u_wdata = ud;
          uk_d    = uk_q - 1'b1;
          state_d = S_UI_RD;
        end else begin
          state_d = S_UI_PUT;
        end
      end
      S_UI_PUT: begin
        u_we    = 1'b1;
        u_waddr = uk_q[UIDX_W-1:0];
        u_wdata = '{owner: owner_q, base: rb_q, len: rs_q};
        ucnt_d  = ucnt_q + 1'b1;
        fsum_d  = fsum_q - rs_q;
        state_d = S_DONE;
      end

      // Search the used table for the owner.
      S_FS_RD: begin
        if (UCNT_W'(i_q) < ucnt_q) begin
          u_raddr = i_q[UIDX_W-1:0];
          state_d = S_FS_CHK;
        end else begin
          st_d    = ST_NO_OWNER;
          state_d = S_DONE;
        end
      end
      S_FS_CHK: begin
        if (ud.owner == owner_q) begin
          rb_d    = ud.base;
          rs_d    = ud.len;
          uk_d    = UCNT_W'(i_q);
          state_d = S_UR_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_FS_RD;
        end
      end

      // Close the gap in the used table.
      S_UR_RD: begin
        if (UCNT_W'(uk_q + 1'b1) < ucnt_q) begin
          u_raddr = UIDX_W'(uk_q + 1'b1);
          state_d = S_UR_WR;
        end else begin
          ucnt_d  = ucnt_q - 1'b1;
          fsum_d  = fsum_q + rs_q;
          nb_d    = rb_q;
          nl_d    = rs_q;
          below_d = 1'b0;
          above_d = 1'b0;
          i_d     = '0;
          state_d = S_CO_RD;
        end
      end
      S_UR_WR: begin
        u_we    = 1'b1;
        u_waddr = uk_q[UIDX_W-1:0];
        u_wdata = ud;
        uk_d    = uk_q + 1'b1;
        state_d = S_UR_RD;
      end

      // Find and remove the neighbor holes below and above.
      S_CO_RD: begin
        if ((i_q < hcnt_q) && !(below_q && above_q)) begin
          h_raddr = i_q[HIDX_W-1:0];
          state_d = S_CO_CHK;
        end else if (hcnt_q >= HCNT_W'(HOLE_SLOTS)) begin
          state_d = S_DONE;
        end else begin
          k_d     = hcnt_q;
          state_d = S_HI_RD;
        end
      end
      S_CO_CHK: begin
        if (!below_q && (hole_end == {1'b0, rb_q})) begin
          below_d = 1'b1;
          nb_d    = hd.base;
          nl_d    = nl_q + hd.len;
          k_d     = i_q;
          ret_d   = S_CO_RD;
          state_d = S_HR_RD;
        end else if (!above_q && ({1'b0, hd.base} == rel_end)) begin
          above_d = 1'b1;
          nl_d    = nl_q + hd.len;
          k_d     = i_q;
          ret_d   = S_CO_RD;
          state_d = S_HR_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_CO_RD;
        end
      end

      // Sorted insert of the merged hole.
      S_HI_RD: begin
        if (k_q != '0) begin
          h_raddr = HIDX_W'(k_q - 1'b1);
          state_d = S_HI_CHK;
        end else begin
          state_d = S_HI_PUT;
        end
      end
      S_HI_CHK: begin
        if (hd.base >= nb_q) begin
          h_we    = 1'b1;
          h_waddr = k_q[HIDX_W-1:0];
          h_wdata = hd;
          k_d     = k_q - 1'b1;
          state_d = S_HI_RD;
        end else begin
          state_d = S_HI_PUT;
        end
      end
      S_HI_PUT: begin
        h_we    = 1'b1;
        h_waddr = k_q[HIDX_W-1:0];
        h_wdata = '{base: nb_q, len: nl_q};
        hcnt_d  = hcnt_q + 1'b1;
        state_d = S_DONE;
      end

      // Remove hole k by shifting the rest down, then return.
      S_HR_RD: begin
        if (HCNT_W'(k_q + 1'b1) < hcnt_q) begin
          h_raddr = HIDX_W'(k_q + 1'b1);
          state_d = S_HR_WR;
        end else begin
          hcnt_d  = hcnt_q - 1'b1;
          state_d = ret_q;
        end
      end
      S_HR_WR: begin
        h_we    = 1'b1;
        h_waddr = k_q[HIDX_W-1:0];
        h_wdata = hd;
        k_d     = k_q + 1'b1;
        state_d = S_HR_RD;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (h_we && (h_waddr == '0)) begin
      h0rst_d = 1'b0;
    end
  end

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      hcnt_q  <= HCNT_W'(1);
      ucnt_q  <= '0;
      fsum_q  <= {ADDR_BITS{1'b1}};
      h0rst_q <= 1'b1;
      hrd0_q  <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
      uk_q    <= '0;
      below_q <= 1'b0;
      above_q <= 1'b0;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      hcnt_q  <= hcnt_d;
      ucnt_q  <= ucnt_d;
      fsum_q  <= fsum_d;
      h0rst_q <= h0rst_d;
      hrd0_q  <= (h_raddr == '0);
      i_q     <= i_d;
      k_q     <= k_d;
      uk_q    <= uk_d;
      below_q <= below_d;
      above_q <= above_d;
      st_q    <= st_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rb_q    <= rb_d;
    rs_q    <= rs_d;
    nb_q    <= nb_d;
    nl_q    <= nl_d;
    owner_q <= owner_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{free_total: fsum_q, region_size: rs_q,
                         region_base: rb_q, status: st_q};

endmodule

/* rtl/core/first_fit_segment_allocator.sv */
// First-fit segment allocator: stream ports, config registers, result register.
// Init writes hole 0 and goes straight to its result; allocate and free scan or shift the
// tables one entry at a time, so their run time grows with the number of entries visited.
// One request is in work at a time; the next is taken while a result waits.
// The hole and used memories each have a single registered read port.
// Reset leaves one hole of 65535 at address 0, an empty used table, config 65535/0.
module first_fit_segment_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // cmd[1:0], req_size[17:2], owner_id[25:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // status[2:0], region_base[18:3],
                                      // region_size[34:19], free_total[50:35]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import ffsa_pkg::*;

  logic [ADDR_BITS-1:0] mem_size_q, mem_base_q;
  logic                 idle, res_valid, res_ready, out_valid_q;
  result_t              res, out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= {ADDR_BITS{1'b1}};
      mem_base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE: mem_size_q <= cfg_wdata_i;
        CFG_BASE: mem_base_q <= cfg_wdata_i;
        default:  mem_size_q <= mem_size_q;
      endcase
    end
  end

  assign s_axis_tready = idle;

  ffsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && idle),
    .cmd_i       (s_axis_tdata[1:0]),
    .req_size_i  (s_axis_tdata[17:2]),
    .owner_id_i  (s_axis_tdata[25:18]),
    .cfg_size_i  (mem_size_q),
    .cfg_base_i  (mem_base_q),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};

endmodule
